[hdl/tmlr_pkg.sv]
// Shared constants, types and the palette shading function of the tile map line renderer.
`timescale 1ns / 1ps
package tmlr_pkg;

    localparam int VRAM_BYTES          = 8192;
    localparam int VRAM_AW             = $clog2(VRAM_BYTES);
    localparam int TILES_PER_LINE_DEF  = 32;
    localparam int COL_W               = 5;

    // opcodes of an input item
    localparam logic [1:0] OP_WRITE        = 2'd0;
    localparam logic [1:0] OP_RENDER_BG    = 2'd1;
    localparam logic [1:0] OP_RENDER_WIN   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BG_MAP_HIGH    = 2'd0;
    localparam logic [1:0] CFG_WIN_MAP_HIGH   = 2'd1;
    localparam logic [1:0] CFG_UNSIGNED_DATA  = 2'd2;
    localparam logic [1:0] CFG_BG_PALETTE     = 2'd3;

    // address unit operations
    localparam logic [1:0] AG_MAP   = 2'd0;
    localparam logic [1:0] AG_TILE  = 2'd1;
    localparam logic [1:0] AG_NEXT  = 2'd2;

    localparam logic [VRAM_AW-1:0] SIGNED_DATA_BASE = 13'h0800;

    typedef struct packed {
        logic [1:0]         op;
        logic               map_high;
        logic [4:0]         map_row;
        logic [COL_W-1:0]   col;
        logic [7:0]         tile_id;
        logic               unsigned_data;
        logic [2:0]         tile_row;
        logic [VRAM_AW-1:0] prev_addr;
    } agen_req_t;

    function automatic logic [15:0] shade_row(input logic [7:0] palette,
                                              input logic [7:0] lo,
                                              input logic [7:0] hi);
        logic [15:0] shades;
        logic [1:0]  color;
        shades = '0;
        for (int j = 0; j < 8; j++)
        begin
            color = {hi[7-j], lo[7-j]};
            shades[2*j +: 2] = palette[{color, 1'b0} +: 2];
        end
        return shades;
    endfunction

endpackage

[hdl/tmlr_vram.sv]
// Video memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module tmlr_vram (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [tmlr_pkg::VRAM_AW-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [tmlr_pkg::VRAM_AW-1:0] rd_addr,
    output logic [7:0]                  rd_data
);
    import tmlr_pkg::*;

    logic [7:0] mem [VRAM_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/tmlr_agen.sv]
// Shared address unit: one adder forms map, tile row and second tile byte addresses.
`timescale 1ns / 1ps
module tmlr_agen (
    input  tmlr_pkg::agen_req_t          req,
    output logic [tmlr_pkg::VRAM_AW-1:0] addr
);
    import tmlr_pkg::*;

    logic [VRAM_AW-1:0] base;
    logic [VRAM_AW-1:0] offset;

    always_comb
    begin
        unique case (req.op)
            AG_MAP:
            begin
                // map at 0x1800 or 0x1C00, 32 entries per map row
                base   = {2'b11, req.map_high, 10'd0};
                offset = {3'd0, req.map_row, req.col};
            end
            AG_TILE:
            begin
                if (req.unsigned_data)
                begin
                    base   = '0;
                    offset = {1'b0, req.tile_id, req.tile_row, 1'b0};
                end
                else
                begin
                    base   = SIGNED_DATA_BASE;
                    offset = {1'b0, ~req.tile_id[7], req.tile_id[6:0], req.tile_row, 1'b0};
                end
            end
            AG_NEXT:
            begin
                base   = req.prev_addr;
                offset = {{(VRAM_AW-1){1'b0}}, 1'b1};
            end
            default:
            begin
                base   = '0;
                offset = '0;
            end
        endcase
    end

    assign addr = base + offset;

endmodule

[hdl/tile_map_line_renderer_unit.sv]
// Top level of the tile map line renderer: sequencer, configuration and output register.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) takes one item per beat. Opcode write
//   stores write_byte at vram_offset. Opcode render background or
//   render window reads, for each of TILES_PER_LINE columns, the map byte and
//   the two tile row bytes through the single video memory port and sends one
//   output beat of eight palette-mapped shades per column.
//   Output channel (out_valid / out_stall) is held in an output register.
//   Sequence: each column steps through S_LO, S_HI and S_OUT while the output
//   is free; the three memory reads per column (the map byte, then the two
//   tile row bytes) set the pace. The first beat is registered from S_OUT.
//   in_stall stays high for the whole render. A write or an unknown opcode
//   gives no beat. A stalled output holds the sequencer at the end of its
//   column; the next item is accepted at the edge after the last column
//   enters the output register.
//   Reset clears the sequencer, the output valid and the configuration
//   registers; video memory is undefined until written.
//   Configuration: cfg_write with cfg_index / cfg_data, only while idle.
module tile_map_line_renderer_unit #(
    parameter int TILES_PER_LINE = tmlr_pkg::TILES_PER_LINE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [tmlr_pkg::VRAM_AW-1:0] vram_offset,
    input  logic [7:0]                   write_byte,
    input  logic [7:0]                   line_number,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tmlr_pkg::COL_W-1:0]   tile_column,
    output logic [15:0]                  pixel_shades,
    output logic [7:0]                   out_line,
    output logic                         last_column,
    input  logic                         cfg_write,
    input  logic [1:0]                   cfg_index,
    input  logic [7:0]                   cfg_data
);
    import tmlr_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(TILES_PER_LINE - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LO   = 2'd1;
    localparam logic [1:0] S_HI   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [7:0]         line_reg, line_next;
    logic               win_reg, win_next;
    logic [VRAM_AW-1:0] tile_addr_reg, tile_addr_next;
    logic [7:0]         lo_reg, lo_next;

    logic               bg_map_high_reg;
    logic               window_map_high_reg;
    logic               unsigned_data_reg;
    logic [7:0]         bg_palette_reg;

    logic               out_valid_reg, out_valid_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [15:0]        out_shades_reg, out_shades_next;
    logic [7:0]         out_line_reg, out_line_next;
    logic               out_last_reg, out_last_next;

    logic               accept;
    logic               start;
    logic               out_free;
    logic               col_last;
    logic               rd_en;
    logic [7:0]         rd_data;
    logic [VRAM_AW-1:0] rd_addr;
    agen_req_t          ag_req;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign start    = accept && ((opcode == OP_RENDER_BG) || (opcode == OP_RENDER_WIN));
    assign out_free = !out_valid_reg || !out_stall;
    assign col_last = (col_reg == LAST_COL);

    tmlr_vram u_vram (
        .clk     (clk),
        .wr_en   (accept && (opcode == OP_WRITE)),
        .wr_addr (vram_offset),
        .wr_data (write_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tmlr_agen u_agen (
        .req  (ag_req),
        .addr (rd_addr)
    );

    always_comb
    begin
        ag_req.op            = AG_MAP;
        ag_req.map_high      = win_reg ? window_map_high_reg : bg_map_high_reg;
        ag_req.map_row       = line_reg[7:3];
        ag_req.col           = col_reg + COL_W'(1);
        ag_req.tile_id       = rd_data;
        ag_req.unsigned_data = unsigned_data_reg;
        ag_req.tile_row      = line_reg[2:0];
        ag_req.prev_addr     = tile_addr_reg;

        state_next      = state_reg;
        col_next        = col_reg;
        line_next       = line_reg;
        win_next        = win_reg;
        tile_addr_next  = tile_addr_reg;
        lo_next         = lo_reg;
        rd_en           = 1'b0;

        out_valid_next  = out_valid_reg && out_stall;
        out_col_next    = out_col_reg;
        out_shades_next = out_shades_reg;
        out_line_next   = out_line_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // issue the first map read straight from the input beat
                ag_req.map_high = (opcode == OP_RENDER_WIN) ? window_map_high_reg
                                                            : bg_map_high_reg;
                ag_req.map_row  = line_number[7:3];
                ag_req.col      = '0;
                if (start)
                begin
                    rd_en      = 1'b1;
                    col_next   = '0;
                    line_next  = line_number;
                    win_next   = (opcode == OP_RENDER_WIN);
                    state_next = S_LO;
                end
            end
            S_LO:
            begin
                ag_req.op      = AG_TILE;
                rd_en          = 1'b1;
                tile_addr_next = rd_addr;
                state_next     = S_HI;
            end
            S_HI:
            begin
                ag_req.op  = AG_NEXT;
                rd_en      = 1'b1;
                lo_next    = rd_data;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold read data until the output register frees up
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_col_next    = col_reg;
                    out_shades_next = shade_row(bg_palette_reg, lo_reg, rd_data);
                    out_line_next   = line_reg;
                    out_last_next   = col_last;
                    if (col_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        col_next   = col_reg + COL_W'(1);
                        state_next = S_LO;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            out_valid_reg       <= 1'b0;
            bg_map_high_reg     <= 1'b0;
            window_map_high_reg <= 1'b0;
            unsigned_data_reg   <= 1'b0;
            bg_palette_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_BG_MAP_HIGH:   bg_map_high_reg     <= cfg_data[0];
                    CFG_WIN_MAP_HIGH:  window_map_high_reg <= cfg_data[0];
                    CFG_UNSIGNED_DATA: unsigned_data_reg   <= cfg_data[0];
                    CFG_BG_PALETTE:    bg_palette_reg      <= cfg_data;
                    default:           bg_palette_reg      <= bg_palette_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        line_reg       <= line_next;
        win_reg        <= win_next;
        tile_addr_reg  <= tile_addr_next;
        lo_reg         <= lo_next;
        out_col_reg    <= out_col_next;
        out_shades_reg <= out_shades_next;
        out_line_reg   <= out_line_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign tile_column  = out_col_reg;
    assign pixel_shades = out_shades_reg;
    assign out_line     = out_line_reg;
    assign last_column  = out_last_reg;

`ifndef SYNTHESIS
    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> in_stall)
        else $error("render accepted but block not busy");

    a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HI) |-> ($past(state_reg) == S_LO))
        else $error("second tile byte read without first");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free && col_last) |=> (!in_stall && out_valid && last_column))
        else $error("last column did not end the render");
`endif

endmodule

[tb/tile_map_line_renderer_unit_tb.sv]
// Self-checking testbench of the tile map line renderer: drives writes and renders, checks shade beats.
`timescale 1ns / 1ps
module tile_map_line_renderer_unit_tb;
    import tmlr_pkg::*;

    localparam int          LINE_COLS     = 32;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          LONG_HOLD     = 400;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          ITEM_BUDGET   = 180;
    localparam int          PHASES        = 5;
    localparam logic [1:0]  OP_UNKNOWN    = 2'd3;
    localparam logic [12:0] MAP_LOW_BASE  = 13'h1800;
    localparam logic [12:0] MAP_HIGH_BASE = 13'h1C00;

    typedef struct packed {
        logic [4:0]  col;
        logic [15:0] shades;
        logic [7:0]  line_no;
        logic        last_col;
    } shade_beat_t;

    class tile_row_scoreboard;
        logic [7:0]  vram [VRAM_BYTES];
        logic        bg_map_high   = 1'b0;
        logic        win_map_high  = 1'b0;
        logic        unsigned_data = 1'b0;
        logic [7:0]  palette       = 8'h00;
        shade_beat_t expected_beats [$];
        int          errors        = 0;
        int          beats_checked = 0;
        int          renders       = 0;
        int          writes        = 0;

        function void set_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_BG_MAP_HIGH:   bg_map_high   = data[0];
                CFG_WIN_MAP_HIGH:  win_map_high  = data[0];
                CFG_UNSIGNED_DATA: unsigned_data = data[0];
                CFG_BG_PALETTE:    palette       = data;
                default: ;
            endcase
        endfunction

        function logic [12:0] map_addr(logic [1:0] op, logic [7:0] line_no, logic [4:0] col);
            logic high;
            high = (op == OP_RENDER_BG) ? bg_map_high : win_map_high;
            return (high ? MAP_HIGH_BASE : MAP_LOW_BASE) + {line_no[7:3], col};
        endfunction

        function logic [12:0] tile_row_addr(logic [7:0] id, logic [2:0] row);
            if (unsigned_data)
                return {id, 4'b0000} + {row, 1'b0};
            return SIGNED_DATA_BASE + {id ^ 8'h80, 4'b0000} + {row, 1'b0};
        endfunction

        function logic [15:0] shade_byte_pair(logic [7:0] lo, logic [7:0] hi);
            logic [15:0] shades;
            logic [1:0]  color;
            shades = '0;
            for (int j = 0; j < 8; j++)
            begin
                color = {hi[7 - j], lo[7 - j]};
                case (color)
                    2'd0:    shades[2 * j +: 2] = palette[1:0];
                    2'd1:    shades[2 * j +: 2] = palette[3:2];
                    2'd2:    shades[2 * j +: 2] = palette[5:4];
                    default: shades[2 * j +: 2] = palette[7:6];
                endcase
            end
            return shades;
        endfunction

        function void note_item(logic [1:0] op, logic [12:0] offset, logic [7:0] data,
                                logic [7:0] line_no);
            logic [12:0] addr;
            logic [7:0]  id;
            shade_beat_t beat;
            if (op == OP_WRITE)
            begin
                vram[offset] = data;
                writes++;
                return;
            end
            if (op != OP_RENDER_BG && op != OP_RENDER_WIN)
                return;
            renders++;
            for (int col = 0; col < LINE_COLS; col++)
            begin
                id              = vram[map_addr(op, line_no, 5'(col))];
                addr            = tile_row_addr(id, line_no[2:0]);
                beat.col        = 5'(col);
                beat.shades     = shade_byte_pair(vram[addr], vram[addr + 13'd1]);
                beat.line_no    = line_no;
                beat.last_col   = (col == LINE_COLS - 1);
                expected_beats.insert(expected_beats.size(), beat);
            end
        endfunction

        function void check_beat(shade_beat_t got);
            shade_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: beat with nothing expected: column %0d shades %h line %0d last %0d",
                         $time, got.col, got.shades, got.line_no, got.last_col);
                errors++;
                return;
            end
            want = expected_beats[0];
            expected_beats.delete(0);
            beats_checked++;
            if (got.col !== want.col)
            begin
                $display("%0t: tile_column mismatch, expected %0d, actual %0d",
                         $time, want.col, got.col);
                errors++;
            end
            if (got.shades !== want.shades)
            begin
                $display("%0t: pixel_shades mismatch (column %0d), expected %h, actual %h",
                         $time, want.col, want.shades, got.shades);
                errors++;
            end
            if (got.line_no !== want.line_no)
            begin
                $display("%0t: out_line mismatch, expected %0d, actual %0d",
                         $time, want.line_no, got.line_no);
                errors++;
            end
            if (got.last_col !== want.last_col)
            begin
                $display("%0t: last_column mismatch (column %0d), expected %0d, actual %0d",
                         $time, want.col, want.last_col, got.last_col);
                errors++;
            end
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [1:0]          opcode      = OP_WRITE;
    logic [VRAM_AW-1:0]  vram_offset = '0;
    logic [7:0]          write_byte  = 8'h00;
    logic [7:0]          line_number = 8'h00;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [COL_W-1:0]    tile_column;
    logic [15:0]         pixel_shades;
    logic [7:0]          out_line;
    logic                last_column;
    logic                cfg_write   = 1'b0;
    logic [1:0]          cfg_index   = CFG_BG_MAP_HIGH;
    logic [7:0]          cfg_data    = 8'h00;

    tile_row_scoreboard board = new();
    bit                 written [VRAM_BYTES];
    bit                 idle_on      = 1'b1;
    int                 hold_grants  = 0;
    int                 quiet_cycles = 0;
    int                 sent_items   = 0;

    tile_map_line_renderer_unit i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tile ids at the signed-mode boundaries keep the set of tile rows small
    function automatic logic [7:0] pick_id();
        logic [7:0] id;
        case ($urandom_range(0, 3))
            0:       id = 8'h00;
            1:       id = 8'h7F;
            2:       id = 8'h80;
            default: id = 8'hFF;
        endcase
        return id;
    endfunction

    // lines of the top and bottom map rows only
    function automatic logic [7:0] pick_line();
        logic [4:0] map_row;
        map_row = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'd31;
        return {map_row, 3'($urandom)};
    endfunction

    task automatic send_item(logic [1:0] op, logic [12:0] offset, logic [7:0] data,
                             logic [7:0] line_no);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        vram_offset <= offset;
        write_byte  <= data;
        line_number <= line_no;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_item(op, offset, data, line_no);
        sent_items++;
        if (op == OP_WRITE)
            written[offset] = 1'b1;
    endtask

    task automatic store_byte(logic [12:0] offset, logic [7:0] data);
        send_item(OP_WRITE, offset, data, 8'($urandom));
    endtask

    // write every byte the render will read that has not been written yet
    task automatic prepare_line(logic [1:0] op, logic [7:0] line_no);
        logic [12:0] maddr;
        logic [12:0] taddr;
        for (int col = 0; col < LINE_COLS; col++)
        begin
            maddr = board.map_addr(op, line_no, 5'(col));
            if (!written[maddr])
                store_byte(maddr, pick_id());
            taddr = board.tile_row_addr(board.vram[maddr], line_no[2:0]);
            if (!written[taddr])
                store_byte(taddr, 8'($urandom));
            if (!written[taddr + 13'd1])
                store_byte(taddr + 13'd1, 8'($urandom));
        end
    endtask

    task automatic render_line(logic [1:0] op, logic [7:0] line_no);
        prepare_line(op, line_no);
        send_item(op, 13'($urandom), 8'($urandom), line_no);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [7:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    // upper data bits of the one-bit registers are random and must be dropped
    task automatic apply_config(logic bg, logic win, logic uns, logic [7:0] pal);
        put_reg(CFG_BG_MAP_HIGH, {7'($urandom), bg});
        put_reg(CFG_WIN_MAP_HIGH, {7'($urandom), win});
        put_reg(CFG_UNSIGNED_DATA, {7'($urandom), uns});
        put_reg(CFG_BG_PALETTE, pal);
        cfg_write <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_items(int count);
        int          first_item;
        int          kind;
        logic [1:0]  op;
        logic [7:0]  line_no;
        logic [12:0] maddr;
        logic [12:0] taddr;
        first_item = sent_items;
        while (sent_items - first_item < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                op      = ($urandom_range(0, 1) == 0) ? OP_RENDER_BG : OP_RENDER_WIN;
                line_no = pick_line();
                // retile part of the map row, then repaint part of the tile rows it uses
                repeat ($urandom_range(0, 3))
                    store_byte(board.map_addr(op, line_no, 5'($urandom)), pick_id());
                prepare_line(op, line_no);
                repeat ($urandom_range(0, 3))
                begin
                    maddr = board.map_addr(op, line_no, 5'($urandom));
                    taddr = board.tile_row_addr(board.vram[maddr], line_no[2:0]);
                    store_byte(taddr + 13'($urandom_range(0, 1)), 8'($urandom));
                end
                send_item(op, 13'($urandom), 8'($urandom), line_no);
            end
            else if (kind < 9)
            begin
                store_byte(13'($urandom), 8'($urandom));
            end
            else
            begin
                send_item(OP_UNKNOWN, 13'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial
    begin : result_sink
        shade_beat_t got;
        int          burst_left;
        int          hold_left;
        int          holds_done;
        burst_left = 0;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.col      = tile_column;
                got.shades   = pixel_shades;
                got.line_no  = out_line;
                got.last_col = last_column;
                board.check_beat(got);
            end
            if (holds_done != hold_grants)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]  corner_ids [4];
        logic [7:0]  corner_lo  [4];
        logic [7:0]  corner_hi  [4];
        logic [12:0] taddr;
        int          phase_items;
        corner_ids = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        corner_lo  = '{8'hFF, 8'h00, 8'hFF, 8'hA5};
        corner_hi  = '{8'h00, 8'hFF, 8'hFF, 8'h3C};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tile ids at the signed-mode boundaries, all four colors, corner lines
        apply_config(1'b0, 1'b1, 1'b0, 8'hE4);
        for (int k = 0; k < 4; k++)
        begin
            store_byte(MAP_LOW_BASE + 13'(k), corner_ids[k]);
            taddr = board.tile_row_addr(corner_ids[k], 3'd0);
            store_byte(taddr, corner_lo[k]);
            store_byte(taddr + 13'd1, corner_hi[k]);
        end
        render_line(OP_RENDER_BG, 8'd0);
        send_item(OP_UNKNOWN, 13'h1FFF, 8'hFF, 8'hFF);
        store_byte(13'h1FFF, 8'hFF);
        store_byte(13'h0000, 8'h00);
        render_line(OP_RENDER_WIN, 8'd255);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            if (p == PHASES - 1)
                idle_on = 1'b0;
            case (p)
                0:       apply_config(1'b1, 1'b0, 1'b1, 8'h1B);
                1:       apply_config(1'b1, 1'b1, 1'b1, 8'hFF);
                2:       apply_config(1'b0, 1'b0, 1'b0, 8'h00);
                default: apply_config(1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
            endcase
            phase_items = (ITEM_BUDGET - sent_items) / (PHASES - p);
            // long output hold while renders keep coming
            if (p == 1)
                hold_grants++;
            render_line((p % 2 == 0) ? OP_RENDER_BG : OP_RENDER_WIN, pick_line());
            if (p == 2)
            begin
                random_items(phase_items / 2);
                drain_results();
                random_items(phase_items / 2);
            end
            else
            begin
                random_items(phase_items);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d shade beats from %0d renders and %0d memory writes.",
                 board.beats_checked, board.renders, board.writes);
        $display("Both layers and map bases, signed and unsigned tile data, palettes 00 to FF.");
        if (board.errors == 0 && board.expected_beats.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
